[hdl/lmcd_pkg.sv]
package lmcd_pkg;

  localparam int DEF_MODULE_COUNT = 4;
  localparam int MAX_MODULES      = 4;
  localparam int MOD_IDX_W        = 2;
  localparam int STEP_W           = 3;
  localparam int ROWS             = 8;
  localparam int INIT_STEPS       = 5;
  localparam int LVL_W            = 4;
  localparam int CFG_AW           = 3;

  localparam logic [LVL_W-1:0] INTENSITY_RESET = 4'd3;

  // register index, taken from paddr[2]
  localparam logic REG_INTENSITY = 1'b0;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_REFRESH = 2'd1,
    OP_INIT    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic                 load;     // produce one byte into the output stage
    logic                 init;     // 1: init sequence, 0: refresh
    logic [STEP_W-1:0]    step;     // row or init register step
    logic [MOD_IDX_W-1:0] mod;      // position in the chain, 0 = sent first
    logic                 half;     // 0: address byte, 1: data byte
    logic                 eot;
    logic                 eor;
    logic                 pix_wr;   // set pixel request accepted
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic load_ok;
  } stat_t;

  function automatic logic [7:0] init_reg(input logic [STEP_W-1:0] s);
    case (s)
      3'd0:    init_reg = 8'h09;  // decode mode
      3'd1:    init_reg = 8'h0A;  // intensity
      3'd2:    init_reg = 8'h0B;  // scan limit
      3'd3:    init_reg = 8'h0C;  // shutdown
      default: init_reg = 8'h0F;  // display test
    endcase
  endfunction

  function automatic logic [7:0] init_val(input logic [STEP_W-1:0] s,
                                          input logic [LVL_W-1:0]  lvl);
    case (s)
      3'd0:    init_val = 8'h00;
      3'd1:    init_val = {4'h0, lvl};
      3'd2:    init_val = 8'h07;
      3'd3:    init_val = 8'h01;
      default: init_val = 8'h00;
    endcase
  endfunction

endpackage

[hdl/lmcd_ctrl.sv]
module lmcd_ctrl
  import lmcd_pkg::*;
#(
  parameter int MODS = DEF_MODULE_COUNT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  localparam int MOD_W = (MODS > 1) ? $clog2(MODS) : 1;
  localparam logic [MOD_W-1:0] MOD_MAX = MOD_W'(MODS - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic              init_r, init_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [MOD_W-1:0]  mod_r, mod_nxt;
  logic              half_r, half_nxt;

  logic accept, last_mod, last_step, load;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign last_mod  = (mod_r == MOD_MAX);
  assign last_step = init_r ? (step_r == STEP_W'(INIT_STEPS - 1))
                            : (step_r == STEP_W'(ROWS - 1));
  assign load      = (state_r == ST_RUN) && stat.load_ok;

  always_comb begin
    state_nxt = state_r;
    init_nxt  = init_r;
    step_nxt  = step_r;
    mod_nxt   = mod_r;
    half_nxt  = half_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_REFRESH || in_op == OP_INIT)) begin
          state_nxt = ST_RUN;
          init_nxt  = (in_op == OP_INIT);
          step_nxt  = '0;
          mod_nxt   = '0;
          half_nxt  = 1'b0;
        end
      end
      ST_RUN: begin
        if (load) begin
          half_nxt = !half_r;
          if (half_r) begin
            if (last_mod) begin
              mod_nxt = '0;
              if (last_step) begin
                state_nxt = ST_IDLE;
              end else begin
                step_nxt = step_r + 1'b1;
              end
            end else begin
              mod_nxt = mod_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      init_r  <= 1'b0;
      step_r  <= '0;
      mod_r   <= '0;
      half_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      step_r  <= step_nxt;
      mod_r   <= mod_nxt;
      half_r  <= half_nxt;
    end
  end

  always_comb begin
    cmd.load   = load;
    cmd.init   = init_r;
    cmd.step   = step_r;
    cmd.mod    = MOD_IDX_W'(mod_r);
    cmd.half   = half_r;
    cmd.eot    = half_r && last_mod;
    cmd.eor    = half_r && last_mod && last_step;
    cmd.pix_wr = accept && (in_op == OP_SET);
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> stat.load_ok)
    else $error("byte produced while output stage full");

  a_eor_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && cmd.eor) |=> in_ready)
    else $error("controller did not return to idle after last byte");

  a_eor_is_eot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && cmd.eor) |-> cmd.eot)
    else $error("end of run without end of transfer");

  a_no_byte_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.load)
    else $error("byte produced while idle");

endmodule

[hdl/lmcd_dpath.sv]
module lmcd_dpath
  import lmcd_pkg::*;
#(
  parameter int MODS = DEF_MODULE_COUNT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [5:0]       pixel_x,
  input  logic [3:0]       pixel_y,
  input  logic             pixel_on,
  input  logic [LVL_W-1:0] intensity,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_eot,
  output logic             out_eor
);

  localparam int MOD_W = (MODS > 1) ? $clog2(MODS) : 1;
  localparam logic [MOD_W-1:0] MOD_MAX = MOD_W'(MODS - 1);
  localparam logic [6:0] X_LIMIT = 7'(MODS * 8);

  logic [7:0] store_r [MODS][ROWS];

  logic             in_range;
  logic [MOD_W-1:0] pm, rd_mod;
  logic [7:0]       nxt_byte;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_eot_r, out_eor_r;

  assign in_range = ({1'b0, pixel_x} < X_LIMIT) && !pixel_y[3];
  assign pm       = pixel_x[3 +: MOD_W];
  // chain is fed last module first
  assign rd_mod   = MOD_MAX - cmd.mod[MOD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < MODS; m++) begin
        for (int r = 0; r < ROWS; r++) begin
          store_r[m][r] <= '0;
        end
      end
    end else if (cmd.pix_wr && in_range) begin
      store_r[pm][pixel_y[2:0]][pixel_x[2:0]] <= pixel_on;
    end
  end

  always_comb begin
    if (cmd.init) begin
      nxt_byte = cmd.half ? init_val(cmd.step, intensity) : init_reg(cmd.step);
    end else begin
      nxt_byte = cmd.half ? store_r[rd_mod][cmd.step]
                          : ({5'b0, cmd.step} + 8'd1);
    end
  end

  assign stat.load_ok = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte_r <= nxt_byte;
      out_eot_r  <= cmd.eot;
      out_eor_r  <= cmd.eor;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_eot   = out_eot_r;
  assign out_eor   = out_eor_r;

endmodule

[hdl/led_matrix_chain_frame_driver.sv]
// Frame buffer driver for a daisy chain of 8x8 LED matrix modules. Each input
// request carries a command in in_tuser: set pixel updates one bit of the
// frame buffer and produces nothing; refresh streams 8 rows x MODULE_COUNT
// (address, data) byte pairs, last module first; initialize streams 5 register
// writes x MODULE_COUNT byte pairs (decode off, intensity, scan limit 7,
// normal operation, test off). Bytes leave one per cycle while out_tready is
// high. A new request is taken once the controller has issued the last byte of
// the current run; the final byte may still sit in the output stage. out_tlast
// marks the last byte of each chip-select transfer, out_tuser the last byte of
// the command. Out-of-range pixels and the unused command code are dropped.
// The intensity register (address 0) is written over the APB port and should
// only change while the block is idle.
module led_matrix_chain_frame_driver
  import lmcd_pkg::*;
#(
  parameter int MODULE_COUNT = DEF_MODULE_COUNT
) (
  input  logic              clk,
  input  logic              rst_n,
  // input requests
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [5:0] pixel_x, [9:6] pixel_y, [10] pixel_on
  input  logic [1:0]        in_tuser,   // [1:0] operation
  // output bytes
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] serial_byte
  output logic              out_tlast,  // end_of_transfer
  output logic [0:0]        out_tuser,  // [0] end_of_run
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // chain length outside 1..4 is pinned to the nearest bound
  localparam int MODS = (MODULE_COUNT < 1) ? 1 :
                        ((MODULE_COUNT > MAX_MODULES) ? MAX_MODULES : MODULE_COUNT);

  logic [LVL_W-1:0] intensity_r;
  logic             cfg_wr;
  cmd_t             cmd;
  stat_t            stat;
  logic             eor;

  // APB: zero wait states; register index is paddr[2]
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intensity_r <= INTENSITY_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_INTENSITY) begin
      intensity_r <= cfg_pwdata[LVL_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_INTENSITY) ? {28'h0, intensity_r} : 32'h0;

  // sequencer: walks rows / init steps, modules and byte halves
  lmcd_ctrl #(.MODS(MODS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // frame buffer, byte select and output stage
  lmcd_dpath #(.MODS(MODS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .pixel_x   (in_tdata[5:0]),
    .pixel_y   (in_tdata[9:6]),
    .pixel_on  (in_tdata[10]),
    .intensity (intensity_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_eot   (out_tlast),
    .out_eor   (eor)
  );

  assign out_tuser = eor;

endmodule
